FILE: sv/alst_pkg.sv
package alst_pkg;

    // Field widths of the request and result channels
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // Default list capacity
    localparam int DEPTH_DEF = 64;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH   = 3'd0,
        K_POP    = 3'd1,
        K_INSERT = 3'd2,
        K_DELETE = 3'd3,
        K_FIND   = 3'd4,
        K_READ   = 3'd5,
        K_REMOVE = 3'd6
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    // Kind of memory walk
    typedef enum logic [1:0] {
        WK_INS  = 2'd0,
        WK_DEL  = 2'd1,
        WK_FIND = 2'd2,
        WK_REM  = 2'd3
    } t_walk;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    wr_word;
        logic    wr_at_pos;
        logic    rd_last;
        logic    rd_pos;
        logic    fill_inc;
        logic    fill_dec;
        logic    fill_keep;
        logic    walk_init;
        t_walk   walk;
        logic    scan;
        logic    find_hit;
        logic    finish;
        t_status status;
        logic    take_rd;
        logic    take_fp;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic pos_gt_fill;
        logic pos_ge_fill;
        logic pos_eq_fill;
        logic pos_last;
        logic more;
        logic dvalid;
        logic hit;
        logic keep_eq_fill;
        logic out_free;
    } t_sts;

endpackage

FILE: sv/alst_if.sv
interface alst_req_if;
    logic                              valid;
    logic                              ready;
    logic [alst_pkg::KIND_W-1:0]       kind;
    logic signed [alst_pkg::VALUE_W-1:0] value;
    logic [alst_pkg::POS_W-1:0]        position;

    modport source (output valid, kind, value, position, input ready);
    modport sink (input valid, kind, value, position, output ready);
endinterface

interface alst_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [alst_pkg::STATUS_W-1:0]       status;
    logic signed [alst_pkg::VALUE_W-1:0] read_value;
    logic [alst_pkg::POS_W-1:0]          found_position;
    logic [alst_pkg::COUNT_W-1:0]        count;

    modport source (output valid, status, read_value, found_position, count, input ready);
    modport sink (input valid, status, read_value, found_position, count, output ready);
endinterface

FILE: sv/alst_ctrl.sv
module alst_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [alst_pkg::KIND_W-1:0] i_kind,
    input  alst_pkg::t_sts              i_sts,
    output alst_pkg::t_cmd              o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    alst_pkg::t_kind   r_kind, n_kind;
    alst_pkg::t_status r_status, n_status;
    logic              r_take_rd, n_take_rd;
    logic              r_take_fp, n_take_fp;

    // Sequence one request at a time
    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_status  = r_status;
        n_take_rd = r_take_rd;
        n_take_fp = r_take_fp;
        o_cmd     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_kind     = alst_pkg::t_kind'(i_kind);
                    n_status   = alst_pkg::ST_OK;
                    n_take_rd  = 1'b0;
                    n_take_fp  = 1'b0;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_DONE;
                unique case (r_kind)
                    alst_pkg::K_PUSH: begin
                        if (i_sts.full) begin
                            n_status = alst_pkg::ST_FULL;
                        end else begin
                            o_cmd.wr_word  = 1'b1;
                            o_cmd.fill_inc = 1'b1;
                        end
                    end
                    alst_pkg::K_POP: begin
                        if (i_sts.empty) begin
                            n_status = alst_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.rd_last  = 1'b1;
                            o_cmd.fill_dec = 1'b1;
                            n_take_rd      = 1'b1;
                        end
                    end
                    alst_pkg::K_INSERT: begin
                        if (i_sts.pos_gt_fill) begin
                            n_status = alst_pkg::ST_BADPOS;
                        end else if (i_sts.full) begin
                            n_status = alst_pkg::ST_FULL;
                        end else if (i_sts.pos_eq_fill) begin
                            o_cmd.wr_word   = 1'b1;
                            o_cmd.wr_at_pos = 1'b1;
                            o_cmd.fill_inc  = 1'b1;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            o_cmd.walk      = alst_pkg::WK_INS;
                            n_state         = S_SCAN;
                        end
                    end
                    alst_pkg::K_DELETE: begin
                        if (i_sts.empty) begin
                            n_status = alst_pkg::ST_EMPTY;
                        end else if (i_sts.pos_ge_fill) begin
                            n_status = alst_pkg::ST_BADPOS;
                        end else if (i_sts.pos_last) begin
                            o_cmd.fill_dec = 1'b1;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            o_cmd.walk      = alst_pkg::WK_DEL;
                            n_state         = S_SCAN;
                        end
                    end
                    alst_pkg::K_FIND: begin
                        if (i_sts.empty) begin
                            n_status = alst_pkg::ST_NOTFOUND;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            o_cmd.walk      = alst_pkg::WK_FIND;
                            n_state         = S_SCAN;
                        end
                    end
                    alst_pkg::K_READ: begin
                        if (i_sts.empty) begin
                            n_status = alst_pkg::ST_EMPTY;
                        end else if (i_sts.pos_ge_fill) begin
                            n_status = alst_pkg::ST_BADPOS;
                        end else begin
                            o_cmd.rd_pos = 1'b1;
                            n_take_rd    = 1'b1;
                        end
                    end
                    alst_pkg::K_REMOVE: begin
                        if (i_sts.empty) begin
                            n_status = alst_pkg::ST_NOTFOUND;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            o_cmd.walk      = alst_pkg::WK_REM;
                            n_state         = S_SCAN;
                        end
                    end
                    default: begin
                        // unused kind: report ok, change nothing
                        n_status = alst_pkg::ST_OK;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (r_kind == alst_pkg::K_FIND && i_sts.hit) begin
                    // stop at the first match
                    o_cmd.find_hit = 1'b1;
                    n_take_fp      = 1'b1;
                    n_state        = S_DONE;
                end else if (!i_sts.more && !i_sts.dvalid) begin
                    n_state = S_DONE;
                    unique case (r_kind)
                        alst_pkg::K_INSERT: begin
                            o_cmd.wr_word   = 1'b1;
                            o_cmd.wr_at_pos = 1'b1;
                            o_cmd.fill_inc  = 1'b1;
                        end
                        alst_pkg::K_DELETE: begin
                            o_cmd.fill_dec = 1'b1;
                        end
                        alst_pkg::K_REMOVE: begin
                            o_cmd.fill_keep = 1'b1;
                            n_status = i_sts.keep_eq_fill ? alst_pkg::ST_NOTFOUND
                                                          : alst_pkg::ST_OK;
                        end
                        default: begin
                            n_status = alst_pkg::ST_NOTFOUND;
                        end
                    endcase
                end
            end
            S_DONE: begin
                // hand the result over once the output register is free
                if (i_sts.out_free) begin
                    o_cmd.finish  = 1'b1;
                    o_cmd.status  = r_status;
                    o_cmd.take_rd = r_take_rd;
                    o_cmd.take_fp = r_take_fp;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_kind    <= n_kind;
        r_status  <= n_status;
        r_take_rd <= n_take_rd;
        r_take_fp <= n_take_fp;
    end

endmodule

FILE: sv/alst_dpath.sv
module alst_dpath #(
    parameter int DEPTH = alst_pkg::DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic signed [alst_pkg::VALUE_W-1:0]  i_value,
    input  logic [alst_pkg::POS_W-1:0]           i_position,
    input  alst_pkg::t_cmd                       i_cmd,
    output alst_pkg::t_sts                       o_sts,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [alst_pkg::STATUS_W-1:0]        o_status,
    output logic signed [alst_pkg::VALUE_W-1:0]  o_read_value,
    output logic [alst_pkg::POS_W-1:0]           o_found_position,
    output logic [alst_pkg::COUNT_W-1:0]         o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int CW = ((FW > alst_pkg::POS_W) ? FW : alst_pkg::POS_W) + 1;

    logic [alst_pkg::VALUE_W-1:0] mem [DEPTH];

    logic [alst_pkg::VALUE_W-1:0] r_value;
    logic [alst_pkg::POS_W-1:0]   r_pos;
    logic [FW-1:0]                r_fill;
    logic [FW-1:0]                r_keep;
    logic [AW-1:0]                r_rptr;
    logic [AW-1:0]                r_stop;
    logic [AW-1:0]                r_didx;
    logic [AW-1:0]                r_fpos;
    logic                         r_more;
    logic                         r_dvalid;
    alst_pkg::t_walk              r_walk;
    logic [alst_pkg::VALUE_W-1:0] r_rdata;
    logic                         r_out_valid;
    alst_pkg::t_status            r_o_status;
    logic [alst_pkg::VALUE_W-1:0] r_o_rd;
    logic [alst_pkg::POS_W-1:0]   r_o_fp;
    logic [alst_pkg::COUNT_W-1:0] r_o_count;

    logic [CW-1:0]                pos_ext;
    logic [CW-1:0]                fill_ext;
    logic [AW-1:0]                pos_a;
    logic [AW-1:0]                last_a;
    logic                         step;
    logic                         wstage;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic                         we;
    logic [AW-1:0]                wa;
    logic [alst_pkg::VALUE_W-1:0] wd;
    logic                         mismatch;

    assign pos_ext  = CW'(r_pos);
    assign fill_ext = CW'(r_fill);
    assign pos_a    = AW'(r_pos);
    assign last_a   = AW'(r_fill - FW'(1));
    assign step     = i_cmd.scan && r_more;
    assign wstage   = i_cmd.scan && r_dvalid;
    assign mismatch = (r_rdata != r_value);

    // Report list conditions to the controller
    always_comb begin
        o_sts.empty        = (r_fill == '0);
        o_sts.full         = (r_fill == FW'(DEPTH));
        o_sts.pos_gt_fill  = (pos_ext > fill_ext);
        o_sts.pos_ge_fill  = (pos_ext >= fill_ext);
        o_sts.pos_eq_fill  = (pos_ext == fill_ext);
        o_sts.pos_last     = ((pos_ext + CW'(1)) == fill_ext);
        o_sts.more         = r_more;
        o_sts.dvalid       = r_dvalid;
        o_sts.hit          = r_dvalid && !mismatch;
        o_sts.keep_eq_fill = (r_keep == r_fill);
        o_sts.out_free     = !r_out_valid || i_out_ready;
    end

    // Select the read address
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_rptr;
        if (step) begin
            rd_addr = r_rptr;
        end else if (i_cmd.rd_last) begin
            rd_addr = last_a;
        end else if (i_cmd.rd_pos) begin
            rd_addr = pos_a;
        end else begin
            rd_en = 1'b0;
        end
    end

    // Select the write: a new word, or a word moved by the walk
    always_comb begin
        we = 1'b0;
        wa = r_didx;
        wd = r_rdata;
        if (i_cmd.wr_word) begin
            we = 1'b1;
            wa = i_cmd.wr_at_pos ? pos_a : AW'(r_fill);
            wd = r_value;
        end else if (wstage) begin
            case (r_walk)
                alst_pkg::WK_INS: begin
                    we = 1'b1;
                    wa = r_didx + AW'(1);
                end
                alst_pkg::WK_DEL: begin
                    we = 1'b1;
                    wa = r_didx - AW'(1);
                end
                alst_pkg::WK_REM: begin
                    we = mismatch;
                    wa = AW'(r_keep);
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
    end

    // Entry store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Capture the request and walk the entries
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
            r_pos   <= i_position;
        end
        if (i_cmd.walk_init) begin
            r_walk <= i_cmd.walk;
            r_keep <= '0;
            case (i_cmd.walk)
                alst_pkg::WK_INS: begin
                    r_rptr <= last_a;
                    r_stop <= pos_a;
                end
                alst_pkg::WK_DEL: begin
                    r_rptr <= AW'(pos_ext + CW'(1));
                    r_stop <= last_a;
                end
                default: begin
                    r_rptr <= '0;
                    r_stop <= last_a;
                end
            endcase
        end else begin
            if (step) begin
                r_rptr <= (r_walk == alst_pkg::WK_INS) ? r_rptr - AW'(1)
                                                       : r_rptr + AW'(1);
            end
            if (i_cmd.scan) begin
                r_didx <= r_rptr;
            end
            if (wstage && r_walk == alst_pkg::WK_REM && mismatch) begin
                r_keep <= r_keep + FW'(1);
            end
        end
        if (i_cmd.find_hit) begin
            r_fpos <= r_didx;
        end
    end

    // Walk control flags and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_more   <= 1'b0;
            r_dvalid <= 1'b0;
        end else begin
            if (i_cmd.walk_init) begin
                r_more   <= 1'b1;
                r_dvalid <= 1'b0;
            end else if (i_cmd.scan) begin
                r_dvalid <= step;
                if (step && r_rptr == r_stop) begin
                    r_more <= 1'b0;
                end
            end
            if (i_cmd.fill_inc) begin
                r_fill <= r_fill + FW'(1);
            end else if (i_cmd.fill_dec) begin
                r_fill <= r_fill - FW'(1);
            end else if (i_cmd.fill_keep) begin
                r_fill <= r_keep;
            end
        end
    end

    // Output register: hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.finish) begin
            r_o_status <= i_cmd.status;
            r_o_rd     <= i_cmd.take_rd ? r_rdata : '0;
            r_o_fp     <= i_cmd.take_fp ? alst_pkg::POS_W'(r_fpos) : '0;
            r_o_count  <= alst_pkg::COUNT_W'(r_fill);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_read_value     = r_o_rd;
    assign o_found_position = r_o_fp;
    assign o_count          = r_o_count;

endmodule

FILE: sv/array_list_engine_unit.sv
// Ordered list of signed 32-bit words with DEPTH places.
// Request channel i_req (valid/ready, kind, value, position): push, pop,
// insert, delete, find, read or remove every copy of a word. Result channel
// o_rsp (valid/ready, status, read_value, found_position, count) gives one
// result per request, in order.
// One request is worked at a time; i_req.ready is high only while the
// controller is idle. Push, pop, read, errors, the unused kind, an insert
// at the fill level and a delete of the last word go from the check state
// straight to the done state. Other inserts and deletes, find and remove
// walk the stored words through the single read port of the entry memory,
// one word a cycle, up to DEPTH words (64 by default); a find that hits
// stops at its first match. Once the result is registered the controller
// returns to idle, where it takes the next request.
// The result sits in an output register; the next request is accepted and
// worked while it waits, and only the handover of that request's result
// waits for o_rsp.ready.
// Reset empties the list (count zero) and drops any pending result; the
// memory itself is not cleared and needs no pass after reset.
module array_list_engine_unit #(
    parameter int DEPTH = alst_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    alst_req_if.sink  i_req,
    alst_rsp_if.source o_rsp
);

    alst_pkg::t_cmd cmd;
    alst_pkg::t_sts sts;

    alst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_kind     (i_req.kind),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    alst_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_value          (i_req.value),
        .i_position       (i_req.position),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_out_valid      (o_rsp.valid),
        .i_out_ready      (o_rsp.ready),
        .o_status         (o_rsp.status),
        .o_read_value     (o_rsp.read_value),
        .o_found_position (o_rsp.found_position),
        .o_count          (o_rsp.count)
    );

endmodule

FILE: verif/alst_list_checker.sv
`timescale 1ns / 1ps

// Watch both channels of the list engine, keep a shadow copy of the list,
// predict one result per accepted request and compare results in order.
module alst_list_checker
    import alst_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    alst_req_if  i_req,
    alst_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_list_fill
);

    typedef struct packed {
        t_status              status;
        logic [VALUE_W-1:0]   read_value;
        logic [POS_W-1:0]     found_position;
        logic [COUNT_W-1:0]   count;
    } list_result_t;

    // Shadow list contents and fill level
    logic [VALUE_W-1:0] shadow_words [DEPTH];
    int                 shadow_fill;
    list_result_t       result_q [$];

    // Print one line per mismatch and count it
    task automatic report_error(input string msg);
        $display("%0t ns list check: %s", $time, msg);
        o_fail_count++;
    endtask

    // Apply one request to the shadow list and work out its result
    function automatic list_result_t apply_request(
        input logic [KIND_W-1:0]  kind,
        input logic [VALUE_W-1:0] word,
        input logic [POS_W-1:0]   pos
    );
        list_result_t res;
        int           idx;
        int           keep;
        bit           hit;
        res        = '0;
        res.status = ST_OK;
        hit        = 1'b0;
        keep       = 0;
        case (kind)
            K_PUSH: begin
                if (shadow_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_words[shadow_fill] = word;
                    shadow_fill++;
                end
            end
            K_POP: begin
                if (shadow_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_fill--;
                    res.read_value = shadow_words[shadow_fill];
                end
            end
            K_INSERT: begin
                // Position check comes ahead of the full check
                if (int'(pos) > shadow_fill) begin
                    res.status = ST_BADPOS;
                end else if (shadow_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (idx = shadow_fill; idx > int'(pos); idx--) begin
                        shadow_words[idx] = shadow_words[idx-1];
                    end
                    shadow_words[pos] = word;
                    shadow_fill++;
                end
            end
            K_DELETE: begin
                if (shadow_fill == 0) begin
                    res.status = ST_EMPTY;
                end else if (int'(pos) >= shadow_fill) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (idx = int'(pos); idx + 1 < shadow_fill; idx++) begin
                        shadow_words[idx] = shadow_words[idx+1];
                    end
                    shadow_fill--;
                end
            end
            K_FIND: begin
                res.status = ST_NOTFOUND;
                for (idx = 0; idx < shadow_fill; idx++) begin
                    if (!hit && shadow_words[idx] == word) begin
                        hit                = 1'b1;
                        res.status         = ST_OK;
                        res.found_position = POS_W'(idx);
                    end
                end
            end
            K_READ: begin
                if (shadow_fill == 0) begin
                    res.status = ST_EMPTY;
                end else if (int'(pos) >= shadow_fill) begin
                    res.status = ST_BADPOS;
                end else begin
                    res.read_value = shadow_words[pos];
                end
            end
            K_REMOVE: begin
                // Compact the survivors, keeping their order
                for (idx = 0; idx < shadow_fill; idx++) begin
                    if (shadow_words[idx] != word) begin
                        shadow_words[keep] = shadow_words[idx];
                        keep++;
                    end
                end
                res.status  = (keep == shadow_fill) ? ST_NOTFOUND : ST_OK;
                shadow_fill = keep;
            end
            default: begin
                // Spare kind: no change
            end
        endcase
        res.count = COUNT_W'(shadow_fill);
        return res;
    endfunction

    // Compare results against the oldest prediction, then log new requests
    always @(posedge i_clk) begin : watch_channels
        list_result_t want;
        if (!i_rst_n) begin
            shadow_fill = 0;
            result_q.delete();
        end else begin
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) begin
                if (result_q.size() == 0) begin
                    report_error("result with no request outstanding");
                end else begin
                    want = result_q.pop_front();
                    if (i_rsp.status !== want.status) begin
                        report_error($sformatf("status want %0d got %0d",
                                               want.status, i_rsp.status));
                    end
                    if (i_rsp.read_value !== want.read_value) begin
                        report_error($sformatf("read_value want %h got %h",
                                               want.read_value, i_rsp.read_value));
                    end
                    if (i_rsp.found_position !== want.found_position) begin
                        report_error($sformatf("found_position want %0d got %0d",
                                               want.found_position, i_rsp.found_position));
                    end
                    if (i_rsp.count !== want.count) begin
                        report_error($sformatf("count want %0d got %0d",
                                               want.count, i_rsp.count));
                    end
                end
            end
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1) begin
                result_q.push_back(apply_request(i_req.kind, i_req.value, i_req.position));
            end
        end
        o_pending   = result_q.size();
        o_list_fill = shadow_fill;
    end

endmodule

FILE: verif/array_list_engine_unit_tb.sv
`timescale 1ns / 1ps

module array_list_engine_unit_tb;
    import alst_pkg::*;

    localparam int ITEM_TARGET  = 1250;
    localparam int BLOCK_LEN    = 40;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 120;
    localparam int POOL_N       = 6;

    // Kind code with no operation behind it
    localparam logic [KIND_W-1:0] K_SPARE = 3'd7;

    // Request mixes: cumulative percentages for push, pop, insert, delete,
    // find, read and remove; whatever is left goes to the spare kind
    localparam int MIX_GROW   = 0;
    localparam int MIX_SHRINK = 1;
    localparam int MIX_EVEN   = 2;
    localparam int KIND_MIX [3][7] = '{
        '{40, 46, 71, 77, 86, 94, 98},
        '{ 8, 33, 40, 65, 75, 85, 98},
        '{14, 28, 42, 56, 70, 84, 98}
    };

    logic i_clk;
    logic i_rst_n;
    bit   quiet_mode;
    int   item_n;
    int   cycle_n;
    int   fail_count;
    int   pending_n;
    int   list_fill;

    logic [VALUE_W-1:0] word_pool [POOL_N];

    alst_req_if req_ch ();
    alst_rsp_if rsp_ch ();

    array_list_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    alst_list_checker u_list_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_n),
        .o_list_fill  (list_fill)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_n++;
        if (cycle_n > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one request after a random gap and hold it until taken
    task automatic send_request(
        input logic [KIND_W-1:0]  kind,
        input logic [VALUE_W-1:0] word,
        input logic [POS_W-1:0]   pos
    );
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.kind     <= kind;
        req_ch.value    <= word;
        req_ch.position <= pos;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drop valid and hold the sender until every outstanding result is back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_n != 0) @(negedge i_clk);
    endtask

    // Draw one request from the given mix, mostly with words from the pool
    // and positions inside the list
    task automatic send_random(input int mix);
        int                 pick;
        int                 pr;
        int                 k;
        int                 fill_now;
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] word;
        logic [POS_W-1:0]   pos;
        fill_now = list_fill;
        pick     = $urandom_range(0, 99);
        kind     = K_SPARE;
        for (k = 6; k >= 0; k--) begin
            if (pick < KIND_MIX[mix][k]) kind = KIND_W'(k);
        end
        word = ($urandom_range(0, 3) != 0) ? word_pool[$urandom_range(0, POOL_N-1)]
                                           : $urandom;
        pr = $urandom_range(0, 99);
        if (pr < 15) begin
            pos = POS_W'($urandom_range(0, 63));
        end else if (kind == K_INSERT) begin
            pos = POS_W'($urandom_range(0, (fill_now > 63) ? 63 : fill_now));
        end else if (fill_now == 0) begin
            pos = '0;
        end else if (pr < 25) begin
            pos = POS_W'(fill_now - 1);
        end else begin
            pos = POS_W'($urandom_range(0, fill_now - 1));
        end
        send_request(kind, word, pos);
        if (kind != K_SPARE) item_n++;
    endtask

    // Result side: stall a random number of cycles before each result
    initial begin : result_sink
        int stall;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = quiet_mode ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (rsp_ch.valid !== 1'b1) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int blk;
        int mix;
        int k;
        req_ch.valid    = 1'b0;
        req_ch.kind     = '0;
        req_ch.value    = '0;
        req_ch.position = '0;
        i_rst_n         = 1'b0;
        quiet_mode      = 1'b0;
        item_n          = 0;
        blk             = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list: every request that needs a word fails
        send_request(K_POP,    32'h0000_0000, 6'd0);
        send_request(K_DELETE, 32'h0000_0000, 6'd0);
        send_request(K_READ,   32'h0000_0000, 6'd0);
        send_request(K_FIND,   32'h0000_0000, 6'd0);
        send_request(K_REMOVE, 32'h0000_0000, 6'd0);
        send_request(K_INSERT, 32'h1234_5678, 6'd1);
        // Insert at the fill level appends; push ignores the position
        send_request(K_INSERT, 32'h7fff_ffff, 6'd0);
        send_request(K_PUSH,   32'h8000_0000, 6'd63);
        send_request(K_PUSH,   32'hffff_ffff, 6'd0);
        send_request(K_PUSH,   32'hffff_ffff, 6'd0);
        send_request(K_INSERT, 32'h0000_0000, 6'd2);
        send_request(K_INSERT, 32'h5555_5555, 6'd6);
        send_request(K_INSERT, 32'haaaa_aaaa, 6'd5);
        // First of two copies, reads in and out of range
        send_request(K_FIND,   32'hffff_ffff, 6'd0);
        send_request(K_READ,   32'h0000_0000, 6'd0);
        send_request(K_READ,   32'h0000_0000, 6'd63);
        send_request(K_DELETE, 32'h0000_0000, 6'd6);
        send_request(K_DELETE, 32'h0000_0000, 6'd0);
        // Remove both copies, then spare kind, delete last, pop, find
        send_request(K_REMOVE, 32'hffff_ffff, 6'd0);
        send_request(K_SPARE,  32'hffff_ffff, 6'd63);
        send_request(K_DELETE, 32'h0000_0000, 6'd2);
        send_request(K_POP,    32'h0000_0000, 6'd0);
        send_request(K_FIND,   32'h8000_0000, 6'd0);
        item_n = 22;

        // Let the pipeline empty before the random part
        wait_drained();

        // Random blocks: grow first so the full list is reached early
        while (item_n < ITEM_TARGET) begin
            for (k = 0; k < POOL_N; k++) begin
                case ($urandom_range(0, 7))
                    0:       word_pool[k] = 32'h8000_0000;
                    1:       word_pool[k] = 32'h7fff_ffff;
                    2:       word_pool[k] = 32'hffff_ffff;
                    default: word_pool[k] = $urandom;
                endcase
            end
            mix        = (blk < 2) ? MIX_GROW : $urandom_range(MIX_GROW, MIX_EVEN);
            quiet_mode = ($urandom_range(0, 4) == 0);
            if (blk == 12) wait_drained();
            repeat (BLOCK_LEN) send_random(mix);
            blk++;
        end

        // Drop valid, wait for the last results and a margin
        quiet_mode = 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/alst_pkg.sv
sv/alst_if.sv
sv/alst_ctrl.sv
sv/alst_dpath.sv
sv/array_list_engine_unit.sv
verif/alst_list_checker.sv
verif/array_list_engine_unit_tb.sv
